FILE: rtl/quaternion_arithmetic_unit_defines.svh
// assertion macros for the quaternion arithmetic unit checker
`ifndef QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH
`define QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define QAU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quaternion unit check failed");

// next-cycle implication, quiet during reset
`define QAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("quaternion unit check failed");

// next-cycle implication that also holds across reset
`define QAU_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("quaternion unit check failed");

`endif

FILE: rtl/qau_pkg.sv
// shared types, constants and helpers of the quaternion arithmetic unit
package qau_pkg;

  localparam int CompW    = 16;
  localparam int FracBits = 14;
  localparam int Comps    = 4;
  localparam int NormW    = 2 * CompW + 1;
  localparam int ProdW    = 2 * CompW;
  localparam int SumW     = ProdW + 2;
  localparam int ShW      = SumW - FracBits;
  localparam int RootW    = CompW + 1;
  localparam int SqRemW   = RootW + 1;
  localparam int QuoW     = FracBits + 1;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_NORM = 3'd3,
    CMD_UNIT = 3'd4
  } qau_cmd_t;

  // operand selection and signs of the hamilton product, one row per component
  localparam logic [1:0] IDX_A [Comps][Comps] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3}
  };
  localparam logic [1:0] IDX_B [Comps][Comps] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };
  localparam logic NEG [Comps][Comps] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0}
  };

  // one item as it travels down the root and divide stages
  typedef struct packed {
    qau_cmd_t                               cmd;
    logic [Comps-1:0][CompW-1:0]            res;
    logic [NormW-1:0]                       nsq;
    logic                                   ovf;
    logic [Comps-1:0]                       neg;
    logic [NormW:0]                         sq_src;
    logic [SqRemW-1:0]                      sq_rem;
    logic [RootW-1:0]                       root;
    logic [Comps-1:0][RootW-1:0]            dv_rem;
    logic [Comps-1:0][FracBits:0]           dv_src;
    logic [Comps-1:0][QuoW-1:0]             quo;
  } qau_pipe_t;

  // clamp a wide signed value to the component range, top bit flags a clamp
  function automatic logic [CompW:0] sat(input logic signed [ShW-1:0] v);
    logic signed [ShW-1:0] hi;
    logic signed [ShW-1:0] lo;
    hi = ShW'((1 << (CompW - 1)) - 1);
    lo = -hi - ShW'(1);
    if (v > hi) begin
      sat = {1'b1, hi[CompW-1:0]};
    end else if (v < lo) begin
      sat = {1'b1, lo[CompW-1:0]};
    end else begin
      sat = {1'b0, v[CompW-1:0]};
    end
  endfunction

endpackage

FILE: rtl/qau_if.sv
// handshake channels of the quaternion arithmetic unit
interface qau_req_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          command;
  logic signed [qau_pkg::CompW-1:0]    a_w;
  logic signed [qau_pkg::CompW-1:0]    a_x;
  logic signed [qau_pkg::CompW-1:0]    a_y;
  logic signed [qau_pkg::CompW-1:0]    a_z;
  logic signed [qau_pkg::CompW-1:0]    b_w;
  logic signed [qau_pkg::CompW-1:0]    b_x;
  logic signed [qau_pkg::CompW-1:0]    b_y;
  logic signed [qau_pkg::CompW-1:0]    b_z;
  modport source (output valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  input ready);
  modport sink (input valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                output ready);
endinterface

interface qau_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [qau_pkg::CompW-1:0]    res_w;
  logic signed [qau_pkg::CompW-1:0]    res_x;
  logic signed [qau_pkg::CompW-1:0]    res_y;
  logic signed [qau_pkg::CompW-1:0]    res_z;
  logic [qau_pkg::NormW-1:0]           norm_sq;
  logic                                overflow;
  logic                                zero_norm;
  modport source (output valid, res_w, res_x, res_y, res_z, norm_sq, overflow, zero_norm,
                  input ready);
  modport sink (input valid, res_w, res_x, res_y, res_z, norm_sq, overflow, zero_norm,
                output ready);
endinterface

FILE: rtl/quaternion_arithmetic_unit.sv
// quaternion arithmetic unit: add, subtract, hamilton product, squared norm, normalise
//
//   channel   dir   beat contents
//   req       in    command, a_w..a_z, b_w..b_z
//   rsp       out   res_w..res_z, norm_sq, overflow, zero_norm
//
// one beat accepted per cycle while rsp is not stalled; each beat passes every stage in turn
// (3 front stages, 17 square root digit stages, 15 quotient bit stages, output)
// the whole pipeline advances together whenever the output register is empty or taken
// a stalled rsp holds every stage, so req.ready drops only while rsp is stalled
// synchronous reset clears the valid bits of every stage; data registers are not reset
module quaternion_arithmetic_unit (
  input  logic        clk,
  input  logic        rst,
  qau_req_if.sink     req,
  qau_rsp_if.source   rsp
);

  localparam int SqSteps  = qau_pkg::RootW;
  localparam int DivSteps = qau_pkg::QuoW;

  logic                                          en;
  logic                                          front_v;
  qau_pkg::qau_pipe_t                            front_item;
  logic [qau_pkg::Comps-1:0][qau_pkg::CompW-1:0] in_a;
  logic [qau_pkg::Comps-1:0][qau_pkg::CompW-1:0] in_b;

  qau_pkg::qau_pipe_t sq_in   [SqSteps];
  qau_pkg::qau_pipe_t sq_out  [SqSteps];
  qau_pkg::qau_pipe_t sq_pipe [SqSteps];
  logic               sq_v    [SqSteps];
  qau_pkg::qau_pipe_t dv_in   [DivSteps];
  qau_pkg::qau_pipe_t dv_out  [DivSteps];
  qau_pkg::qau_pipe_t dv_pipe [DivSteps];
  logic               dv_v    [DivSteps];

  qau_pkg::qau_pipe_t                            last;
  logic [qau_pkg::Comps-1:0][qau_pkg::CompW-1:0] res_c;
  logic                                          ovf_c;
  logic                                          zn_c;

  // global advance
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  assign in_a = {req.a_z, req.a_y, req.a_x, req.a_w};
  assign in_b = {req.b_z, req.b_y, req.b_x, req.b_w};

  qau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req.valid),
    .in_cmd    (qau_pkg::qau_cmd_t'(req.command)),
    .in_a      (in_a),
    .in_b      (in_b),
    .out_valid (front_v),
    .out_item  (front_item)
  );

  // square root digit stages
  for (genvar g = 0; g < SqSteps; g++) begin : g_sqrt
    if (g == 0) begin : g_first
      assign sq_in[g] = front_item;
    end else begin : g_rest
      assign sq_in[g] = sq_pipe[g-1];
    end

    qau_sqrt_step u_step (.d(sq_in[g]), .q(sq_out[g]));

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[g] <= 1'b0;
      end else if (en) begin
        sq_v[g] <= (g == 0) ? front_v : sq_v[(g == 0) ? 0 : g-1];
      end
      if (en) begin
        sq_pipe[g] <= sq_out[g];
      end
    end
  end

  // quotient bit stages
  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    if (g == 0) begin : g_first
      assign dv_in[g] = sq_pipe[SqSteps-1];
    end else begin : g_rest
      assign dv_in[g] = dv_pipe[g-1];
    end

    qau_div_step u_step (.d(dv_in[g]), .q(dv_out[g]));

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[g] <= 1'b0;
      end else if (en) begin
        dv_v[g] <= (g == 0) ? sq_v[SqSteps-1] : dv_v[(g == 0) ? 0 : g-1];
      end
      if (en) begin
        dv_pipe[g] <= dv_out[g];
      end
    end
  end

  // normalise result select
  always_comb begin
    last  = dv_pipe[DivSteps-1];
    res_c = last.res;
    ovf_c = last.ovf;
    zn_c  = 1'b0;
    if (last.cmd == qau_pkg::CMD_UNIT) begin
      ovf_c = 1'b0;
      if (last.nsq == '0) begin
        zn_c  = 1'b1;
        res_c = '0;
      end else begin
        for (int i = 0; i < qau_pkg::Comps; i++) begin
          if (last.neg[i]) begin
            res_c[i] = qau_pkg::CompW'(-{1'b0, last.quo[i]});
          end else begin
            res_c[i] = qau_pkg::CompW'(last.quo[i]);
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= dv_v[DivSteps-1];
    end
    if (en) begin
      rsp.res_w     <= res_c[0];
      rsp.res_x     <= res_c[1];
      rsp.res_y     <= res_c[2];
      rsp.res_z     <= res_c[3];
      rsp.norm_sq   <= last.nsq;
      rsp.overflow  <= ovf_c;
      rsp.zero_norm <= zn_c;
    end
  end

endmodule

FILE: rtl/qau_front.sv
// front stages: operand capture, products and squares, sums and saturation
module qau_front (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  qau_pkg::qau_cmd_t                        in_cmd,
  input  logic [qau_pkg::Comps-1:0][qau_pkg::CompW-1:0] in_a,
  input  logic [qau_pkg::Comps-1:0][qau_pkg::CompW-1:0] in_b,
  output logic                                     out_valid,
  output qau_pkg::qau_pipe_t                       out_item
);

  // stage one registers
  logic                                                v1;
  qau_pkg::qau_cmd_t                                   cmd1;
  logic signed [qau_pkg::CompW-1:0]                    a1 [qau_pkg::Comps];
  logic signed [qau_pkg::CompW-1:0]                    b1 [qau_pkg::Comps];

  // stage two registers
  logic                                                v2;
  qau_pkg::qau_cmd_t                                   cmd2;
  logic signed [qau_pkg::ProdW-1:0]                    prod2 [qau_pkg::Comps][qau_pkg::Comps];
  logic [qau_pkg::ProdW-2:0]                           sq2 [qau_pkg::Comps];
  logic signed [qau_pkg::CompW:0]                      as2 [qau_pkg::Comps];
  logic [qau_pkg::CompW-1:0]                           mag2 [qau_pkg::Comps];
  logic [qau_pkg::Comps-1:0]                           neg2;

  // stage two logic
  logic signed [qau_pkg::ProdW-1:0]                    prod_c [qau_pkg::Comps][qau_pkg::Comps];
  logic signed [qau_pkg::ProdW-1:0]                    sqf_c [qau_pkg::Comps];
  logic signed [qau_pkg::CompW:0]                      as_c [qau_pkg::Comps];
  logic [qau_pkg::CompW-1:0]                           mag_c [qau_pkg::Comps];

  // stage three logic
  qau_pkg::qau_pipe_t                                  item_c;
  logic signed [qau_pkg::SumW-1:0]                     acc;
  logic [qau_pkg::CompW:0]                             st;
  logic [qau_pkg::NormW-1:0]                           nsq_c;

  // operand capture
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      cmd1 <= in_cmd;
      for (int i = 0; i < qau_pkg::Comps; i++) begin
        a1[i] <= in_a[i];
        b1[i] <= in_b[i];
      end
    end
  end

  // sixteen cross products, four squares, the component sums or differences and the magnitudes
  always_comb begin
    for (int i = 0; i < qau_pkg::Comps; i++) begin
      for (int k = 0; k < qau_pkg::Comps; k++) begin
        prod_c[i][k] = a1[qau_pkg::IDX_A[i][k]] * b1[qau_pkg::IDX_B[i][k]];
      end
      sqf_c[i] = a1[i] * a1[i];
      if (cmd1 == qau_pkg::CMD_SUB) begin
        as_c[i] = (qau_pkg::CompW+1)'(a1[i]) - (qau_pkg::CompW+1)'(b1[i]);
      end else begin
        as_c[i] = (qau_pkg::CompW+1)'(a1[i]) + (qau_pkg::CompW+1)'(b1[i]);
      end
      mag_c[i] = a1[i][qau_pkg::CompW-1] ? qau_pkg::CompW'(-a1[i]) : a1[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      cmd2 <= cmd1;
      for (int i = 0; i < qau_pkg::Comps; i++) begin
        for (int k = 0; k < qau_pkg::Comps; k++) begin
          prod2[i][k] <= prod_c[i][k];
        end
        sq2[i]   <= sqf_c[i][qau_pkg::ProdW-2:0];
        as2[i]   <= as_c[i];
        mag2[i]  <= mag_c[i];
        neg2[i]  <= a1[i][qau_pkg::CompW-1];
      end
    end
  end

  // exact sums, floor shift, saturation and result select
  always_comb begin
    item_c     = '0;
    item_c.cmd = cmd2;
    nsq_c      = '0;
    acc        = '0;
    st         = '0;
    for (int i = 0; i < qau_pkg::Comps; i++) begin
      nsq_c = nsq_c + qau_pkg::NormW'(sq2[i]);
      acc = '0;
      for (int k = 0; k < qau_pkg::Comps; k++) begin
        if (qau_pkg::NEG[i][k]) begin
          acc = acc - qau_pkg::SumW'(prod2[i][k]);
        end else begin
          acc = acc + qau_pkg::SumW'(prod2[i][k]);
        end
      end
      unique case (cmd2)
        qau_pkg::CMD_ADD, qau_pkg::CMD_SUB: begin
          st = qau_pkg::sat(qau_pkg::ShW'(as2[i]));
        end
        qau_pkg::CMD_MUL: begin
          st = qau_pkg::sat(acc[qau_pkg::SumW-1:qau_pkg::FracBits]);
        end
        default: begin
          st = '0;
        end
      endcase
      item_c.res[i]    = st[qau_pkg::CompW-1:0];
      item_c.ovf       = item_c.ovf | st[qau_pkg::CompW];
      item_c.neg[i]    = neg2[i];
      item_c.dv_rem[i] = qau_pkg::RootW'(mag2[i][qau_pkg::CompW-1:1]);
      item_c.dv_src[i] = {mag2[i][0], qau_pkg::FracBits'(0)};
    end
    item_c.nsq    = nsq_c;
    item_c.sq_src = {1'b0, nsq_c};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      out_item <= item_c;
    end
  end

endmodule

FILE: rtl/qau_sqrt_step.sv
// one digit of the square root: two bits of the squared norm in, one root bit out
module qau_sqrt_step (
  input  qau_pkg::qau_pipe_t d,
  output qau_pkg::qau_pipe_t q
);

  logic [qau_pkg::SqRemW+1:0] rem_n;
  logic [qau_pkg::SqRemW+1:0] trial;
  logic                       ge;

  // trial subtraction of 4r+1
  always_comb begin
    rem_n = {d.sq_rem, d.sq_src[qau_pkg::NormW:qau_pkg::NormW-1]};
    trial = {1'b0, d.root, 2'b01};
    ge    = rem_n >= trial;
    q        = d;
    q.sq_src = {d.sq_src[qau_pkg::NormW-2:0], 2'b00};
    q.root   = {d.root[qau_pkg::RootW-2:0], ge};
    if (ge) begin
      q.sq_rem = qau_pkg::SqRemW'(rem_n - trial);
    end else begin
      q.sq_rem = rem_n[qau_pkg::SqRemW-1:0];
    end
  end

endmodule

FILE: rtl/qau_div_step.sv
// one quotient bit of the four component divisions by the root
module qau_div_step (
  input  qau_pkg::qau_pipe_t d,
  output qau_pkg::qau_pipe_t q
);

  logic [qau_pkg::RootW:0] rem_n;
  logic                    ge;

  // restoring step per lane, all lanes share the divisor
  always_comb begin
    q     = d;
    rem_n = '0;
    ge    = 1'b0;
    for (int i = 0; i < qau_pkg::Comps; i++) begin
      rem_n       = {d.dv_rem[i], d.dv_src[i][qau_pkg::FracBits]};
      ge          = rem_n >= {1'b0, d.root};
      q.dv_src[i] = {d.dv_src[i][qau_pkg::FracBits-1:0], 1'b0};
      q.quo[i]    = {d.quo[i][qau_pkg::QuoW-2:0], ge};
      if (ge) begin
        q.dv_rem[i] = qau_pkg::RootW'(rem_n - {1'b0, d.root});
      end else begin
        q.dv_rem[i] = rem_n[qau_pkg::RootW-1:0];
      end
    end
  end

endmodule

FILE: rtl/qau_checker.sv
// port-level checks of the quaternion arithmetic unit, bound to the top level
`include "quaternion_arithmetic_unit_defines.svh"

module qau_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] res_w,
  input logic [15:0] res_x,
  input logic [15:0] res_y,
  input logic [15:0] res_z,
  input logic [32:0] norm_sq,
  input logic        overflow,
  input logic        zero_norm
);

  // a stalled result beat holds its valid, res_w and norm_sq
  `QAU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(res_w) && $stable(norm_sq))

  // a zero norm result carries zero components and no saturation
  `QAU_ASSERT_NOW(a_zero_norm_res, rsp_valid && zero_norm, res_w == 16'd0 && res_x == 16'd0 && res_y == 16'd0 && res_z == 16'd0 && norm_sq == 33'd0 && !overflow)

  // input is refused only while a result is stalled
  `QAU_ASSERT_NOW(a_ready_stall, !req_ready, rsp_valid && !rsp_ready)

  // reset empties the output
  `QAU_ASSERT_RESET(a_reset_empty, rst, !rsp_valid)

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .res_w     (rsp.res_w),
  .res_x     (rsp.res_x),
  .res_y     (rsp.res_y),
  .res_z     (rsp.res_z),
  .norm_sq   (rsp.norm_sq),
  .overflow  (rsp.overflow),
  .zero_norm (rsp.zero_norm)
);
